/* rtl/caf_pkg.sv */
// Package for the processor ALU flag unit: item types, flag type and operation codes.
package caf_pkg;

    // Operation codes carried in the action field
    localparam logic [4:0] ACT_ADD    = 5'd0;
    localparam logic [4:0] ACT_ADC    = 5'd1;
    localparam logic [4:0] ACT_SUB    = 5'd2;
    localparam logic [4:0] ACT_SBC    = 5'd3;
    localparam logic [4:0] ACT_AND    = 5'd4;
    localparam logic [4:0] ACT_XOR    = 5'd5;
    localparam logic [4:0] ACT_OR     = 5'd6;
    localparam logic [4:0] ACT_CP     = 5'd7;
    localparam logic [4:0] ACT_INC    = 5'd8;
    localparam logic [4:0] ACT_DEC    = 5'd9;
    localparam logic [4:0] ACT_RLC    = 5'd10;
    localparam logic [4:0] ACT_RRC    = 5'd11;
    localparam logic [4:0] ACT_RL     = 5'd12;
    localparam logic [4:0] ACT_RR     = 5'd13;
    localparam logic [4:0] ACT_SLA    = 5'd14;
    localparam logic [4:0] ACT_SRA    = 5'd15;
    localparam logic [4:0] ACT_SWAP   = 5'd16;
    localparam logic [4:0] ACT_SRL    = 5'd17;
    localparam logic [4:0] ACT_BIT    = 5'd18;
    localparam logic [4:0] ACT_RES    = 5'd19;
    localparam logic [4:0] ACT_SET    = 5'd20;
    localparam logic [4:0] ACT_DAA    = 5'd21;
    localparam logic [4:0] ACT_CPL    = 5'd22;
    localparam logic [4:0] ACT_CCF    = 5'd23;
    localparam logic [4:0] ACT_SCF    = 5'd24;
    localparam logic [4:0] ACT_ADD16  = 5'd25;
    localparam logic [4:0] ACT_ADDSP  = 5'd26;
    localparam logic [4:0] ACT_LDFLAG = 5'd27;

    // Decimal adjust constants
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    // One input item
    typedef struct packed {
        logic [4:0]  action;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic        accumulator_form;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [15:0] result;
        logic        flag_zero;
        logic        flag_subtract;
        logic        flag_half;
        logic        flag_carry;
    } t_out_item;

    // Kept flag register
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

endpackage

/* rtl/caf_core.sv */
// Combinational ALU datapath: one operation and its new flags from an item and the kept flags.
module caf_core (
    input  caf_pkg::t_in_item  i_item,
    input  caf_pkg::t_flags    i_flags,
    output caf_pkg::t_out_item o_item
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [8:0]  dif9;
    logic [4:0]  dif5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] sp_off;
    logic [8:0]  sp_lo9;
    logic [4:0]  sp_lo5;
    logic [7:0]  bit_mask;
    logic [7:0]  daa_t;
    logic        daa_c;
    logic [7:0]  r8;
    logic [15:0] r16;
    logic        wide;
    logic        z, n, h, c;

    assign a   = i_item.operand_a[7:0];
    assign b   = i_item.operand_b[7:0];
    assign cin = ((i_item.action == caf_pkg::ACT_ADC) || (i_item.action == caf_pkg::ACT_SBC))
                 ? i_flags.c : 1'b0;

    // Byte add and subtract with nibble carries
    assign sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign dif9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    assign dif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

    // Word add and stack offset add
    assign sum17  = {1'b0, i_item.operand_a} + {1'b0, i_item.operand_b};
    assign sum13  = {1'b0, i_item.operand_a[11:0]} + {1'b0, i_item.operand_b[11:0]};
    assign sp_off = {{8{b[7]}}, b};
    assign sp_lo9 = {1'b0, i_item.operand_a[7:0]} + {1'b0, b};
    assign sp_lo5 = {1'b0, i_item.operand_a[3:0]} + {1'b0, b[3:0]};

    assign bit_mask = 8'h01 << i_item.bit_index;

    // Decimal adjust: high correction first, then low on the partial value
    always_comb begin
        daa_t = a;
        daa_c = i_flags.c;
        if (!i_flags.n) begin
            if (i_flags.c || (a > caf_pkg::DAA_HI_LIMIT)) begin
                daa_t = daa_t + caf_pkg::DAA_HI_ADJ;
                daa_c = 1'b1;
            end
            if (i_flags.h || (daa_t[3:0] > caf_pkg::DAA_LO_LIMIT)) begin
                daa_t = daa_t + caf_pkg::DAA_LO_ADJ;
            end
        end else begin
            if (i_flags.c) begin
                daa_t = daa_t - caf_pkg::DAA_HI_ADJ;
            end
            if (i_flags.h) begin
                daa_t = daa_t - caf_pkg::DAA_LO_ADJ;
            end
        end
    end

    // Operation select; flags default to kept
    always_comb begin
        r8   = 8'd0;
        r16  = 16'd0;
        wide = 1'b0;
        z    = i_flags.z;
        n    = i_flags.n;
        h    = i_flags.h;
        c    = i_flags.c;
        case (i_item.action)
            caf_pkg::ACT_ADD, caf_pkg::ACT_ADC: begin
                r8 = sum9[7:0];
                z  = (sum9[7:0] == 8'd0);
                n  = 1'b0;
                h  = sum5[4];
                c  = sum9[8];
            end
            caf_pkg::ACT_SUB, caf_pkg::ACT_SBC, caf_pkg::ACT_CP: begin
                r8 = (i_item.action == caf_pkg::ACT_CP) ? a : dif9[7:0];
                z  = (dif9[7:0] == 8'd0);
                n  = 1'b1;
                h  = dif5[4];
                c  = dif9[8];
            end
            caf_pkg::ACT_AND: begin
                r8 = a & b;
                z  = ((a & b) == 8'd0);
                n  = 1'b0;
                h  = 1'b1;
                c  = 1'b0;
            end
            caf_pkg::ACT_XOR: begin
                r8 = a ^ b;
                z  = ((a ^ b) == 8'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = 1'b0;
            end
            caf_pkg::ACT_OR: begin
                r8 = a | b;
                z  = ((a | b) == 8'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = 1'b0;
            end
            caf_pkg::ACT_INC: begin
                r8 = a + 8'd1;
                z  = (a == 8'hFF);
                n  = 1'b0;
                h  = (a[3:0] == 4'hF);
            end
            caf_pkg::ACT_DEC: begin
                r8 = a - 8'd1;
                z  = (a == 8'h01);
                n  = 1'b1;
                h  = (a[3:0] == 4'h0);
            end
            caf_pkg::ACT_RLC: begin
                r8 = {a[6:0], a[7]};
                z  = !i_item.accumulator_form && (a == 8'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = a[7];
            end
            caf_pkg::ACT_RRC: begin
                r8 = {a[0], a[7:1]};
                z  = !i_item.accumulator_form && (a == 8'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = a[0];
            end
            caf_pkg::ACT_RL: begin
                r8 = {a[6:0], i_flags.c};
                z  = !i_item.accumulator_form && ({a[6:0], i_flags.c} == 8'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = a[7];
            end
            caf_pkg::ACT_RR: begin
                r8 = {i_flags.c, a[7:1]};
                z  = !i_item.accumulator_form && ({i_flags.c, a[7:1]} == 8'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = a[0];
            end
            caf_pkg::ACT_SLA: begin
                r8 = {a[6:0], 1'b0};
                z  = (a[6:0] == 7'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = a[7];
            end
            caf_pkg::ACT_SRA: begin
                r8 = {a[7], a[7:1]};
                z  = (a[7:1] == 7'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = a[0];
            end
            caf_pkg::ACT_SWAP: begin
                r8 = {a[3:0], a[7:4]};
                z  = (a == 8'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = 1'b0;
            end
            caf_pkg::ACT_SRL: begin
                r8 = {1'b0, a[7:1]};
                z  = (a[7:1] == 7'd0);
                n  = 1'b0;
                h  = 1'b0;
                c  = a[0];
            end
            caf_pkg::ACT_BIT: begin
                r8 = a;
                z  = !a[i_item.bit_index];
                n  = 1'b0;
                h  = 1'b1;
            end
            caf_pkg::ACT_RES: begin
                r8 = a & ~bit_mask;
            end
            caf_pkg::ACT_SET: begin
                r8 = a | bit_mask;
            end
            caf_pkg::ACT_DAA: begin
                r8 = daa_t;
                z  = (daa_t == 8'd0);
                h  = 1'b0;
                c  = daa_c;
            end
            caf_pkg::ACT_CPL: begin
                r8 = ~a;
                n  = 1'b1;
                h  = 1'b1;
            end
            caf_pkg::ACT_CCF: begin
                r8 = a;
                n  = 1'b0;
                h  = 1'b0;
                c  = !i_flags.c;
            end
            caf_pkg::ACT_SCF: begin
                r8 = a;
                n  = 1'b0;
                h  = 1'b0;
                c  = 1'b1;
            end
            caf_pkg::ACT_ADD16: begin
                wide = 1'b1;
                r16  = sum17[15:0];
                n    = 1'b0;
                h    = sum13[12];
                c    = sum17[16];
            end
            caf_pkg::ACT_ADDSP: begin
                wide = 1'b1;
                r16  = i_item.operand_a + sp_off;
                z    = 1'b0;
                n    = 1'b0;
                h    = sp_lo5[4];
                c    = sp_lo9[8];
            end
            caf_pkg::ACT_LDFLAG: begin
                r8 = {a[7:4], 4'h0};
                z  = a[7];
                n  = a[6];
                h  = a[5];
                c  = a[4];
            end
            default: begin
                r8 = 8'd0;
            end
        endcase
    end

    assign o_item.result        = wide ? r16 : {8'd0, r8};
    assign o_item.flag_zero     = z;
    assign o_item.flag_subtract = n;
    assign o_item.flag_half     = h;
    assign o_item.flag_carry    = c;

endmodule

/* rtl/cpu_alu_flag_unit.sv */
// Top level of the processor ALU flag unit: input register, ALU, flag register, result register.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_in_data  (caf_pkg::t_in_item)
//   out      source     o_out_valid / i_out_stall  o_out_data (caf_pkg::t_out_item)
//
// An item waits in the input register until the result register is free and then
// moves into it; one item per cycle sustained while the output does not stall.
// The flag register updates as an item moves into the result register, so the
// next item sees its flags with no bubble.
// Reset clears both valid bits and the flags to zero.
// A stall on the output holds the result; the input stalls only when both stages are full.
module cpu_alu_flag_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  caf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output caf_pkg::t_out_item o_out_data
);

    logic               r_in_valid;
    caf_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    caf_pkg::t_out_item r_out_item;
    caf_pkg::t_flags    r_flags;
    caf_pkg::t_out_item alu_out;
    logic               out_free;
    logic               move;
    logic               take;

    // Stage advance control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign take       = i_in_valid && !o_in_stall;

    caf_core u_core (
        .i_item (r_in_item),
        .i_flags(r_flags),
        .o_item (alu_out)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
        if (take) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register and kept flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
                r_flags     <= {alu_out.flag_zero, alu_out.flag_subtract,
                                alu_out.flag_half, alu_out.flag_carry};
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
        if (move) begin
            r_out_item <= alu_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the processor ALU flag unit with a built-in flag predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Action codes past the last defined operation; the block reports 0 and keeps flags
    localparam logic [4:0] ACT_SPARE_FIRST = caf_pkg::ACT_LDFLAG + 5'd1;
    localparam logic [4:0] ACT_SPARE_LAST  = 5'h1F;
    localparam int         RANDOM_OPS      = 1450;

    typedef struct {
        caf_pkg::t_in_item op;
        int                idle_after;
        bit                drain_first;
    } t_pending;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_out_stall = 1'b0;
    caf_pkg::t_in_item  i_in_data   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    caf_pkg::t_out_item o_out_data;

    t_pending           pending_ops[$];
    caf_pkg::t_out_item results_due[$];
    caf_pkg::t_flags    flag_model;
    int                 mismatch_count = 0;
    int                 idle_left      = 0;
    int                 stall_left     = 0;
    int                 cyc_count      = 0;
    bit                 in_fire        = 1'b0;
    bit                 stimulus_done  = 1'b0;

    cpu_alu_flag_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // Mostly short idle bursts, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Corner values a quarter of the time, otherwise any 16-bit value
    function automatic logic [15:0] pick_operand();
        logic [15:0] corners[12];
        corners = '{16'h0000, 16'h00FF, 16'h000F, 16'h0010, 16'h0099, 16'h009A,
                    16'h0080, 16'h007F, 16'hFFFF, 16'h0FFF, 16'h8000, 16'h0F00};
        if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 11)];
        return 16'($urandom);
    endfunction

    task automatic push_op(input logic [4:0] act, input logic [15:0] a, input logic [15:0] b,
                           input logic [2:0] bi, input logic accf, input int idle,
                           input bit drain);
        t_pending p;
        p.op.action           = act;
        p.op.operand_a        = a;
        p.op.operand_b        = b;
        p.op.bit_index        = bi;
        p.op.accumulator_form = accf;
        p.idle_after          = idle;
        p.drain_first         = drain;
        pending_ops.push_back(p);
    endtask

    // Computes the result and new flags of one operation and updates flag_model
    function automatic caf_pkg::t_out_item alu_predict(caf_pkg::t_in_item it);
        logic [7:0]         a, b, r8;
        logic [15:0]        r, off;
        logic [8:0]         s9;
        logic [4:0]         s5;
        logic [12:0]        s13;
        logic [16:0]        s17;
        logic               cin, z, n, h, c, out_bit;
        caf_pkg::t_out_item res;
        a   = it.operand_a[7:0];
        b   = it.operand_b[7:0];
        z   = flag_model.z;
        n   = flag_model.n;
        h   = flag_model.h;
        c   = flag_model.c;
        r   = '0;
        r8  = '0;
        cin = 1'b0;
        case (it.action)
            caf_pkg::ACT_ADD, caf_pkg::ACT_ADC: begin
                cin = (it.action == caf_pkg::ACT_ADC) && c;
                s9  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
                s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
                r   = {8'h00, s9[7:0]};
                z   = (s9[7:0] == 8'h00);
                n   = 1'b0;
                h   = s5[4];
                c   = s9[8];
            end
            caf_pkg::ACT_SUB, caf_pkg::ACT_SBC, caf_pkg::ACT_CP: begin
                cin = (it.action == caf_pkg::ACT_SBC) && c;
                s9  = {1'b0, a} - {1'b0, b} - {8'd0, cin};
                s5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
                r   = (it.action == caf_pkg::ACT_CP) ? {8'h00, a} : {8'h00, s9[7:0]};
                z   = (s9[7:0] == 8'h00);
                n   = 1'b1;
                h   = s5[4];
                c   = s9[8];
            end
            caf_pkg::ACT_AND, caf_pkg::ACT_XOR, caf_pkg::ACT_OR: begin
                if (it.action == caf_pkg::ACT_AND) r8 = a & b;
                else if (it.action == caf_pkg::ACT_XOR) r8 = a ^ b;
                else r8 = a | b;
                r = {8'h00, r8};
                z = (r8 == 8'h00);
                n = 1'b0;
                h = (it.action == caf_pkg::ACT_AND);
                c = 1'b0;
            end
            caf_pkg::ACT_INC: begin
                r8 = a + 8'd1;
                r  = {8'h00, r8};
                z  = (r8 == 8'h00);
                n  = 1'b0;
                h  = (a[3:0] == 4'hF);
            end
            caf_pkg::ACT_DEC: begin
                r8 = a - 8'd1;
                r  = {8'h00, r8};
                z  = (r8 == 8'h00);
                n  = 1'b1;
                h  = (a[3:0] == 4'h0);
            end
            caf_pkg::ACT_RLC, caf_pkg::ACT_RRC, caf_pkg::ACT_RL, caf_pkg::ACT_RR,
            caf_pkg::ACT_SLA, caf_pkg::ACT_SRA, caf_pkg::ACT_SRL: begin
                case (it.action)
                    caf_pkg::ACT_RLC: begin out_bit = a[7]; r8 = {a[6:0], a[7]}; end
                    caf_pkg::ACT_RRC: begin out_bit = a[0]; r8 = {a[0], a[7:1]}; end
                    caf_pkg::ACT_RL:  begin out_bit = a[7]; r8 = {a[6:0], c}; end
                    caf_pkg::ACT_RR:  begin out_bit = a[0]; r8 = {c, a[7:1]}; end
                    caf_pkg::ACT_SLA: begin out_bit = a[7]; r8 = {a[6:0], 1'b0}; end
                    caf_pkg::ACT_SRA: begin out_bit = a[0]; r8 = {a[7], a[7:1]}; end
                    default:          begin out_bit = a[0]; r8 = {1'b0, a[7:1]}; end
                endcase
                r = {8'h00, r8};
                // accumulator rotate forms always clear zero
                if (it.accumulator_form &&
                    (it.action == caf_pkg::ACT_RLC || it.action == caf_pkg::ACT_RRC ||
                     it.action == caf_pkg::ACT_RL || it.action == caf_pkg::ACT_RR))
                    z = 1'b0;
                else
                    z = (r8 == 8'h00);
                n = 1'b0;
                h = 1'b0;
                c = out_bit;
            end
            caf_pkg::ACT_SWAP: begin
                r8 = {a[3:0], a[7:4]};
                r  = {8'h00, r8};
                z  = (r8 == 8'h00);
                n  = 1'b0;
                h  = 1'b0;
                c  = 1'b0;
            end
            caf_pkg::ACT_BIT: begin
                r = {8'h00, a};
                z = ~a[it.bit_index];
                n = 1'b0;
                h = 1'b1;
            end
            caf_pkg::ACT_RES: r = {8'h00, a & ~(8'h01 << it.bit_index)};
            caf_pkg::ACT_SET: r = {8'h00, a | (8'h01 << it.bit_index)};
            caf_pkg::ACT_DAA: begin
                r8 = a;
                if (!n) begin
                    if (c || a > caf_pkg::DAA_HI_LIMIT) begin
                        r8 = r8 + caf_pkg::DAA_HI_ADJ;
                        c  = 1'b1;
                    end
                    if (h || a[3:0] > caf_pkg::DAA_LO_LIMIT) r8 = r8 + caf_pkg::DAA_LO_ADJ;
                end else begin
                    if (c) r8 = r8 - caf_pkg::DAA_HI_ADJ;
                    if (h) r8 = r8 - caf_pkg::DAA_LO_ADJ;
                end
                r = {8'h00, r8};
                z = (r8 == 8'h00);
                h = 1'b0;
            end
            caf_pkg::ACT_CPL: begin
                r = {8'h00, ~a};
                n = 1'b1;
                h = 1'b1;
            end
            caf_pkg::ACT_CCF, caf_pkg::ACT_SCF: begin
                r = {8'h00, a};
                n = 1'b0;
                h = 1'b0;
                c = (it.action == caf_pkg::ACT_SCF) ? 1'b1 : ~c;
            end
            caf_pkg::ACT_ADD16: begin
                s17 = {1'b0, it.operand_a} + {1'b0, it.operand_b};
                s13 = {1'b0, it.operand_a[11:0]} + {1'b0, it.operand_b[11:0]};
                r   = s17[15:0];
                n   = 1'b0;
                h   = s13[12];
                c   = s17[16];
            end
            caf_pkg::ACT_ADDSP: begin
                off = {{8{b[7]}}, b};
                r   = it.operand_a + off;
                s5  = {1'b0, it.operand_a[3:0]} + {1'b0, b[3:0]};
                s9  = {1'b0, it.operand_a[7:0]} + {1'b0, b};
                z   = 1'b0;
                n   = 1'b0;
                h   = s5[4];
                c   = s9[8];
            end
            caf_pkg::ACT_LDFLAG: begin
                r = {8'h00, a[7:4], 4'h0};
                {z, n, h, c} = a[7:4];
            end
            default: r = '0;
        endcase
        flag_model         = '{z: z, n: n, h: h, c: c};
        res.result         = r;
        res.flag_zero      = z;
        res.flag_subtract  = n;
        res.flag_half      = h;
        res.flag_carry     = c;
        return res;
    endfunction

    // Result check and input capture at the rising edge
    always @(posedge i_clk) begin
        caf_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result transfer, expected none, got %h",
                             $time, o_out_data);
                end else begin
                    want = results_due.pop_front();
                    if (o_out_data !== want) begin
                        mismatch_count++;
                        $display({"%0t: mismatch expected res=%h z%b n%b h%b c%b,",
                                  " got res=%h z%b n%b h%b c%b"},
                                 $time, want.result, want.flag_zero, want.flag_subtract,
                                 want.flag_half, want.flag_carry, o_out_data.result,
                                 o_out_data.flag_zero, o_out_data.flag_subtract,
                                 o_out_data.flag_half, o_out_data.flag_carry);
                    end
                end
            end
            in_fire = i_in_valid && !o_in_stall;
            if (in_fire) results_due.push_back(alu_predict(i_in_data));
        end else begin
            in_fire = 1'b0;
        end
    end

    // Input driver: presents the next pending op once the current transfer is done
    always @(negedge i_clk) begin
        t_pending p;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_ops[0].drain_first && results_due.size() != 0) begin
                i_in_valid <= 1'b0;
            end else begin
                p = pending_ops.pop_front();
                i_in_data  <= p.op;
                i_in_valid <= 1'b1;
                idle_left  <= p.idle_after;
            end
        end
    end

    // Output stall: random bursts, with calm windows of no stall at all
    always @(negedge i_clk) begin
        int n;
        if (i_rst_n) begin
            cyc_count <= cyc_count + 1;
            if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                n = (cyc_count % 1024 < 200) ? 0 : pick_idle();
                i_out_stall <= (n > 0);
                if (n > 0) stall_left <= n - 1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [4:0] act;
        int         idle;
        flag_model = '0;

        // Directed: extremes, every operation and the special cases
        push_op(caf_pkg::ACT_LDFLAG, 16'h00F0, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_ADC,    16'h000F, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_ADD,    16'hFFFF, 16'hFF01, 3'd0, 1'b0, 1, 1'b0);
        push_op(caf_pkg::ACT_SBC,    16'h0000, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_SUB,    16'h0010, 16'h0001, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_CP,     16'h0042, 16'h0042, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_AND,    16'h00FF, 16'h0000, 3'd0, 1'b1, 0, 1'b0);
        push_op(caf_pkg::ACT_XOR,    16'h005A, 16'hA55A, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_OR,     16'hAB00, 16'h0000, 3'd0, 1'b0, 2, 1'b0);
        push_op(caf_pkg::ACT_INC,    16'h00FF, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_DEC,    16'h0010, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_RLC,    16'h0080, 16'h0000, 3'd0, 1'b1, 0, 1'b0);
        push_op(caf_pkg::ACT_RRC,    16'h0001, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_RL,     16'h0080, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_RR,     16'h0000, 16'h0000, 3'd0, 1'b1, 0, 1'b0);
        push_op(caf_pkg::ACT_SLA,    16'h0080, 16'h0000, 3'd0, 1'b1, 0, 1'b0);
        push_op(caf_pkg::ACT_SRA,    16'h0081, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_SWAP,   16'h00F0, 16'h0000, 3'd0, 1'b1, 0, 1'b0);
        push_op(caf_pkg::ACT_SRL,    16'h0001, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_BIT,    16'h007F, 16'h0000, 3'd7, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_RES,    16'h00FF, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_SET,    16'h0000, 16'h0000, 3'd7, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_ADD,    16'h0099, 16'h0001, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_DAA,    16'h009A, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_LDFLAG, 16'h0070, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_DAA,    16'h0000, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_CPL,    16'h0055, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_CCF,    16'h0012, 16'h0000, 3'd0, 1'b0, 0, 1'b1);
        push_op(caf_pkg::ACT_SCF,    16'h0034, 16'h0000, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_ADD16,  16'hFFFF, 16'h0001, 3'd0, 1'b0, 0, 1'b0);
        push_op(caf_pkg::ACT_ADDSP,  16'h00FF, 16'h0080, 3'd0, 1'b0, 0, 1'b0);
        push_op(ACT_SPARE_LAST,      16'hFFFF, 16'hFFFF, 3'd7, 1'b1, 0, 1'b0);

        // Random: flag loads followed by a flag-dependent op, plus free ops
        for (int i = 0; i < RANDOM_OPS; i++) begin
            idle = ((i / 150) % 3 == 1) ? 0 : pick_idle();
            if ($urandom_range(0, 99) < 10) begin
                push_op(caf_pkg::ACT_LDFLAG, pick_operand(), 16'($urandom), 3'($urandom),
                        1'($urandom), pick_idle(), 1'b0);
                i++;
                case ($urandom_range(0, 4))
                    0:       act = caf_pkg::ACT_DAA;
                    1:       act = caf_pkg::ACT_ADC;
                    2:       act = caf_pkg::ACT_SBC;
                    3:       act = ($urandom_range(0, 1) == 0) ? caf_pkg::ACT_RL
                                                               : caf_pkg::ACT_RR;
                    default: act = ($urandom_range(0, 1) == 0) ? caf_pkg::ACT_CCF
                                                               : caf_pkg::ACT_INC;
                endcase
            end else if ($urandom_range(0, 99) < 4) begin
                act = 5'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            end else begin
                act = 5'($urandom_range(caf_pkg::ACT_ADD, caf_pkg::ACT_LDFLAG));
            end
            push_op(act, pick_operand(), pick_operand(), 3'($urandom), 1'($urandom), idle,
                    (i % 300) == 7);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || i_in_valid || results_due.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        stimulus_done = 1'b1;
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        if (!stimulus_done) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

/* filelist.f */
rtl/caf_pkg.sv
rtl/caf_core.sv
rtl/cpu_alu_flag_unit.sv
tb/sv/tb.sv
